@@ hw/rtl/nor_flash_array_controller_top_macros.svh @@
// ---------------------------------------------------------------------------
// NOR flash array controller assertion macros
// Assertion wrappers for the controller RTL; empty in synthesis builds.
// ---------------------------------------------------------------------------
`ifndef NOR_FLASH_ARRAY_CONTROLLER_TOP_MACROS_SVH
`define NOR_FLASH_ARRAY_CONTROLLER_TOP_MACROS_SVH

`ifndef SYNTH
// condition holds at every clock edge out of reset
`define NFAC_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// consequent holds in the cycle after the antecedent
`define NFAC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define NFAC_ASSERT(lbl, cond, msg)
`define NFAC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/nfac_pkg.sv @@
// ---------------------------------------------------------------------------
// NOR flash array controller package
// Shared constants, command codes and controller states.
// ---------------------------------------------------------------------------
package nfac_pkg;

   localparam int SECTOR_BYTES_DEF = 2048;
   localparam int FLASH_BYTES_DEF  = 262144;

   localparam logic [31:0] ERASED_WORD = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      MODE_CHECK   = 3'd0,
      MODE_ERASE   = 3'd1,
      MODE_PROGRAM = 3'd2,
      MODE_FIND    = 3'd3,
      MODE_READ    = 3'd4
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SETUP,
      ST_SCAN,
      ST_ERASE,
      ST_WORD,
      ST_RESP
   } state_type;

endpackage

@@ hw/rtl/nfac_ram.sv @@
// ---------------------------------------------------------------------------
// NOR flash array controller RAM
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module nfac_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/nfac_sector_div.sv @@
// ---------------------------------------------------------------------------
// NOR flash array controller sector offset
// Reduces a byte address to its offset inside the sector by reciprocal
// multiplication and one correcting subtract, each step registered.
// ---------------------------------------------------------------------------
module nfac_sector_div
   import nfac_pkg::*;
#(
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [31:0]                     dividend,
   output logic                            done,
   output logic [$clog2(SECTOR_BYTES)-1:0] rem
);

   localparam int RMW = $clog2(SECTOR_BYTES);
   localparam int EW  = RMW + 1;
   // the quotient of a 32-bit address fits in 33 - RMW bits
   localparam int QW  = 33 - RMW;
   localparam int PW  = 32 + QW;
   localparam longint unsigned RECIP = 64'h1_0000_0000 / SECTOR_BYTES;

   logic           stage1_ff, stage1_in;
   logic           stage2_ff, stage2_in;
   logic           stage3_ff, stage3_in;
   logic           done_ff, done_in;
   logic [31:0]    dvd_ff, dvd_in;
   logic [QW-1:0]  quot_ff, quot_in;
   logic [EW-1:0]  est_ff, est_in;
   logic [RMW-1:0] rem_ff, rem_in;
   logic [PW-1:0]  prod;
   logic [31:0]    back;

   // the quotient estimate is low by at most one, so one subtract corrects it
   assign prod = PW'(dvd_ff) * PW'(RECIP);
   assign back = 32'(quot_ff) * 32'(SECTOR_BYTES);

   always_comb begin
      stage1_in = start;
      stage2_in = stage1_ff;
      stage3_in = stage2_ff;
      done_in   = stage3_ff;
      dvd_in    = start ? dividend : dvd_ff;
      quot_in   = prod[PW-1:32];
      est_in    = EW'(dvd_ff - back);
      rem_in    = (est_ff >= EW'(SECTOR_BYTES)) ? RMW'(est_ff - EW'(SECTOR_BYTES))
                                               : est_ff[RMW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         stage2_ff <= 1'b0;
         stage3_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= stage1_in;
         stage2_ff <= stage2_in;
         stage3_ff <= stage3_in;
         done_ff   <= done_in;
      end
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
      est_ff  <= est_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

@@ hw/rtl/nor_flash_array_controller_top.sv @@
// ---------------------------------------------------------------------------
// NOR flash array controller
// Flash word array with sector check, sector erase, word program, empty
// sector search and word read, one command at a time.
// ---------------------------------------------------------------------------
// Sequence: after reset the array is swept to all ones, and no request is
// taken until the sweep finishes. Read and program read the addressed
// word, then respond. Sector check and erase first reduce the address to
// its sector base in the divider, then make one memory access per cycle.
// Find-first-empty walks the sectors from sector one, one word per cycle,
// up to the whole array. The memory has one write and one registered read
// port, and each walk uses one of them.
// ---------------------------------------------------------------------------
`include "nor_flash_array_controller_top_macros.svh"

module nor_flash_array_controller_top
   import nfac_pkg::*;
#(
   parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
   parameter int FLASH_BYTES  = FLASH_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], address[34:3], data[66:35], allow_first_sector[67],
   // override_config[68], zero pad[71:69]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[0], value[32:1], zero pad[39:33]
   output logic [39:0] rsp_tdata
);

   localparam int FLASH_WORDS = FLASH_BYTES / 4;
   localparam int AW          = $clog2(FLASH_WORDS);
   localparam int CW          = $clog2(FLASH_WORDS + 1);
   localparam int BW          = $clog2(FLASH_BYTES + SECTOR_BYTES + 4);
   localparam int RMW         = $clog2(SECTOR_BYTES);

   // request fields
   logic [2:0]  req_mode;
   logic [31:0] req_address;
   logic [31:0] req_data;
   logic        req_allow_first_sector;
   logic        req_override_config;

   assign req_mode               = req_tdata[2:0];
   assign req_address            = req_tdata[34:3];
   assign req_data               = req_tdata[66:35];
   assign req_allow_first_sector = req_tdata[67];
   assign req_override_config    = req_tdata[68];

   state_type   state_ff, state_in;
   logic [2:0]  mode_ff, mode_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] data_ff, data_in;
   logic        allow_ff, allow_in;
   logic [BW-1:0] base_ff, base_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] end_ff, end_in;
   logic        pend_ff, pend_in;
   logic        res_status_ff, res_status_in;
   logic [31:0] res_value_ff, res_value_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_value_ff, rsp_value_in;

   logic          accept;
   logic          div_start;
   logic          div_done;
   logic [RMW-1:0] div_rem;
   logic [31:0]   div_base;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [31:0]   mem_wdata;
   logic          mem_re;
   logic [AW-1:0] mem_raddr;
   logic [31:0]   mem_rdata;

   // sector bounds, from the sector base
   logic [BW-1:0] sec_end_raw;
   logic [BW-1:0] sec_end;
   logic [BW-1:0] sec_end_word;
   logic [CW-1:0] sec_end_idx;
   logic [CW-1:0] sec_start_idx;

   assign sec_end_raw   = base_ff + BW'(SECTOR_BYTES);
   assign sec_end       = (sec_end_raw > BW'(FLASH_BYTES)) ? BW'(FLASH_BYTES) : sec_end_raw;
   assign sec_end_word  = (sec_end + BW'(3)) >> 2;
   assign sec_end_idx   = (sec_end_word > BW'(FLASH_WORDS)) ? CW'(FLASH_WORDS)
                                                            : CW'(sec_end_word);
   assign sec_start_idx = CW'(base_ff >> 2);

   // word command checks on the incoming request
   logic req_word_ok;
   logic req_prot;

   assign req_word_ok = req_address[31:2] < 30'(FLASH_WORDS);
   assign req_prot    = (req_address < 32'(SECTOR_BYTES)) && !req_allow_first_sector
                        && !req_override_config;

   assign accept    = req_tvalid && req_tready;
   assign div_start = accept && ((req_mode == MODE_CHECK) || (req_mode == MODE_ERASE));
   assign div_base  = addr_ff - 32'(div_rem);

   nfac_sector_div #(
      .SECTOR_BYTES(SECTOR_BYTES)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(req_address),
      .done    (div_done),
      .rem     (div_rem)
   );

   nfac_ram #(
      .WIDTH(32),
      .DEPTH(FLASH_WORDS)
   ) u_ram (
      .clock(clock),
      .we   (mem_we),
      .waddr(mem_waddr),
      .wdata(mem_wdata),
      .re   (mem_re),
      .raddr(mem_raddr),
      .rdata(mem_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      addr_in       = addr_ff;
      data_in       = data_ff;
      allow_in      = allow_ff;
      base_in       = base_ff;
      ptr_in        = ptr_ff;
      end_in        = end_ff;
      pend_in       = pend_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff[AW-1:0];
      mem_wdata     = ERASED_WORD;
      mem_re        = 1'b0;
      mem_raddr     = ptr_ff[AW-1:0];
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + CW'(1);
            if (ptr_ff == CW'(FLASH_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in       = req_mode;
               addr_in       = req_address;
               data_in       = req_data;
               allow_in      = req_allow_first_sector;
               res_status_in = 1'b1;
               res_value_in  = '0;
               mem_raddr     = req_address[AW+1:2];
               unique case (req_mode)
                  MODE_CHECK, MODE_ERASE: begin
                     state_in = ST_DIV;
                  end
                  MODE_FIND: begin
                     base_in  = BW'(SECTOR_BYTES);
                     state_in = ST_SETUP;
                  end
                  MODE_PROGRAM: begin
                     if (req_word_ok && (req_address[1:0] == 2'b00) && !req_prot) begin
                        mem_re   = 1'b1;
                        state_in = ST_WORD;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  MODE_READ: begin
                     if (req_word_ok) begin
                        mem_re   = 1'b1;
                        state_in = ST_WORD;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               base_in = div_base[BW-1:0];
               // drop out-of-range sectors and protected sector zero erases
               if ((div_base >= 32'(FLASH_BYTES)) ||
                   ((mode_ff == MODE_ERASE) && (div_base == '0) && !allow_ff)) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            ptr_in  = sec_start_idx;
            end_in  = sec_end_idx;
            pend_in = 1'b0;
            if (base_ff >= BW'(FLASH_BYTES)) begin
               state_in = ST_RESP;
            end else if (mode_ff == MODE_ERASE) begin
               state_in = ST_ERASE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pend_ff && (mem_rdata != ERASED_WORD)) begin
               // sector not erased: fail a check, advance a search
               if (mode_ff == MODE_FIND) begin
                  base_in  = base_ff + BW'(SECTOR_BYTES);
                  state_in = ST_SETUP;
               end else begin
                  state_in = ST_RESP;
               end
            end else if (ptr_ff < end_ff) begin
               mem_re  = 1'b1;
               ptr_in  = ptr_ff + CW'(1);
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               res_status_in = 1'b0;
               if (mode_ff == MODE_FIND) begin
                  res_value_in = 32'(base_ff);
               end
               state_in = ST_RESP;
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_ERASE: begin
            if (ptr_ff < end_ff) begin
               mem_we = 1'b1;
               ptr_in = ptr_ff + CW'(1);
            end else begin
               res_status_in = 1'b0;
               state_in      = ST_RESP;
            end
         end
         ST_WORD: begin
            if (mode_ff == MODE_READ) begin
               res_status_in = 1'b0;
               res_value_in  = mem_rdata;
            end else if ((mem_rdata & data_ff) == data_ff) begin
               mem_we        = 1'b1;
               mem_waddr     = addr_ff[AW+1:2];
               mem_wdata     = data_ff;
               res_status_in = 1'b0;
            end
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      addr_ff       <= addr_in;
      data_ff       <= data_in;
      allow_ff      <= allow_in;
      base_ff       <= base_in;
      end_ff        <= end_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_value_ff, rsp_status_ff};

   `NFAC_ASSERT(a_walk_bound, !((state_ff == ST_SCAN) || (state_ff == ST_ERASE)) || (ptr_ff <= end_ff), "sector walk ran past its end")
   `NFAC_ASSERT(a_write_range, !mem_we || (CW'(mem_waddr) < CW'(FLASH_WORDS)), "flash write outside the array")
   `NFAC_ASSERT(a_rsp_source, !$rose(rsp_valid_ff) || $past(state_ff == ST_RESP), "response raised outside the response state")
   `NFAC_ASSERT_NEXT(a_accept_busy, accept, state_ff != ST_IDLE, "controller stayed idle after taking a request")

endmodule

@@ tb/flash_cmd_checker.sv @@
// ---------------------------------------------------------------------------
// NOR flash command checker
// Watches the request and result streams of the flash array controller,
// keeps its own image of the array, predicts each result and compares it
// field by field against what the controller returns.
// ---------------------------------------------------------------------------
module flash_cmd_checker
   import nfac_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   // mode[2:0], address[34:3], data[66:35], allow_first_sector[67],
   // override_config[68], zero pad[71:69]
   input  logic [71:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[0], value[32:1], zero pad[39:33]
   input  logic [39:0] rsp_tdata,
   output int          mismatch_count,
   output int          owed_count,
   output int          checked_count
);

   localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;
   localparam int FLASH_BYTES  = FLASH_BYTES_DEF;
   localparam int FLASH_WORDS  = FLASH_BYTES / 4;

   typedef struct {
      logic        status;
      logic [31:0] value;
      logic [2:0]  op;
      logic [31:0] addr;
   } flash_result_type;

   logic [31:0]      flash_image [FLASH_WORDS];
   flash_result_type results_owed [$];
   int               errors;
   int               seen;

   initial begin
      foreach (flash_image[i]) flash_image[i] = ERASED_WORD;
   end

   function automatic int unsigned sector_limit(input int unsigned base);
      int unsigned stop;
      stop = base + SECTOR_BYTES;
      if (stop > FLASH_BYTES) stop = FLASH_BYTES;
      return stop;
   endfunction

   function automatic bit sector_is_erased(input int unsigned base);
      int unsigned w;
      for (w = base / 4; w < sector_limit(base) / 4; w++) begin
         if (flash_image[w] != ERASED_WORD) return 1'b0;
      end
      return 1'b1;
   endfunction

   // Apply one command to the array image and return the result it owes.
   function automatic flash_result_type apply_flash_cmd(input logic [71:0] cmd);
      mode_type         op;
      logic [31:0]      addr;
      logic [31:0]      data;
      logic             allow;
      logic             ovr;
      int unsigned      base;
      int unsigned      w;
      flash_result_type r;
      op       = mode_type'(cmd[2:0]);
      addr     = cmd[34:3];
      data     = cmd[66:35];
      allow    = cmd[67];
      ovr      = cmd[68];
      r.status = 1'b1;
      r.value  = '0;
      r.op     = cmd[2:0];
      r.addr   = addr;
      base     = addr - (addr % SECTOR_BYTES);
      case (op)
         MODE_CHECK: begin
            if (base < FLASH_BYTES && sector_is_erased(base)) r.status = 1'b0;
         end
         MODE_ERASE: begin
            if (base < FLASH_BYTES && (base >= SECTOR_BYTES || allow)) begin
               for (w = base / 4; w < sector_limit(base) / 4; w++)
                  flash_image[w] = ERASED_WORD;
               r.status = 1'b0;
            end
         end
         MODE_PROGRAM: begin
            // program may only clear bits; sector zero needs a flag
            if (addr < FLASH_BYTES && addr[1:0] == 2'b00 &&
                !(addr < SECTOR_BYTES && !allow && !ovr) &&
                (flash_image[addr >> 2] & data) == data) begin
               flash_image[addr >> 2] = data;
               r.status = 1'b0;
            end
         end
         MODE_FIND: begin
            base = SECTOR_BYTES;
            while (base < FLASH_BYTES && r.status) begin
               if (sector_is_erased(base)) begin
                  r.status = 1'b0;
                  r.value  = base;
               end
               base += SECTOR_BYTES;
            end
         end
         MODE_READ: begin
            if (addr < FLASH_BYTES) begin
               r.status = 1'b0;
               r.value  = flash_image[addr >> 2];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      flash_result_type want;
      if (reset) begin
         results_owed.delete();
         owed_count <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen++;
            if (results_owed.size() == 0) begin
               errors++;
               $display("%0t flash_cmd_checker: result with no request outstanding: status %0d value %h",
                        $time, rsp_tdata[0], rsp_tdata[32:1]);
            end else begin
               want = results_owed.pop_front();
               if (rsp_tdata[0] !== want.status) begin
                  errors++;
                  $display("%0t flash_cmd_checker: mode %0d addr %h status expected %0d got %0d",
                           $time, want.op, want.addr, want.status, rsp_tdata[0]);
               end
               if (rsp_tdata[32:1] !== want.value) begin
                  errors++;
                  $display("%0t flash_cmd_checker: mode %0d addr %h value expected %h got %h",
                           $time, want.op, want.addr, want.value, rsp_tdata[32:1]);
               end
            end
         end
         if (req_tvalid && req_tready) results_owed.push_back(apply_flash_cmd(req_tdata));
         owed_count <= results_owed.size();
      end
      mismatch_count <= errors;
      checked_count  <= seen;
   end

endmodule

@@ tb/tb_top.sv @@
// ---------------------------------------------------------------------------
// NOR flash array controller testbench
// Drives directed and random flash commands in bursts with random gaps,
// stalls the result stream on its own pattern, and reports the verdict
// from the checker's mismatch and owed counts.
// ---------------------------------------------------------------------------
module tb_top;
   import nfac_pkg::*;

   localparam int SECTOR_BYTES = SECTOR_BYTES_DEF;
   localparam int FLASH_BYTES  = FLASH_BYTES_DEF;
   localparam int SECTORS      = FLASH_BYTES / SECTOR_BYTES;
   localparam int SECTOR_WORDS = SECTOR_BYTES / 4;
   localparam int LAST_BASE    = FLASH_BYTES - SECTOR_BYTES;
   localparam int RANDOM_GOAL  = 380;
   localparam int CYCLE_LIMIT  = 6_000_000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // mode[2:0], address[34:3], data[66:35], allow_first_sector[67],
   // override_config[68], zero pad[71:69]
   logic [71:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // status[0], value[32:1], zero pad[39:33]
   logic [39:0] rsp_tdata;

   int mismatch_count;
   int owed_count;
   int checked_count;
   int burst_left;
   int items_sent;
   int mode_sent [8];
   int ready_style;
   int style_left;
   int cycles_run;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   nor_flash_array_controller_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   flash_cmd_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .owed_count     (owed_count),
      .checked_count  (checked_count)
   );

   // result side: switch between always ready, coin flip and mostly stalled
   always @(posedge clock) begin
      if (style_left == 0) begin
         ready_style = $urandom_range(0, 2);
         style_left  = $urandom_range(16, 200);
      end
      style_left--;
      case (ready_style)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("tb_top: timeout after %0d cycles, %0d results owed", cycles_run, owed_count);
      $display("tb_top: done, errors");
      $finish;
   end

   task automatic send_cmd(input logic [2:0] op, input logic [31:0] addr,
                           input logic [31:0] data, input logic allow, input logic ovr);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, ovr, allow, data, addr, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mode_sent[op]++;
      items_sent++;
   endtask

   // hold off requests until every owed result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (owed_count != 0) @(posedge clock);
      burst_left = 0;
   endtask

   // keep traffic on a few sectors so the empty-sector search stays short
   function automatic int busy_sector();
      case ($urandom_range(0, 4))
         0:       return 0;
         1:       return 1;
         2:       return 2;
         3:       return 3;
         default: return SECTORS - 1;
      endcase
   endfunction

   function automatic logic [31:0] pick_addr(input bit any_sector);
      int sector;
      sector = any_sector ? $urandom_range(0, SECTORS - 1) : busy_sector();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return 32'(FLASH_BYTES + $urandom_range(0, 4095));
         2:       return '1;
         3:       return 32'(FLASH_BYTES - 1 - $urandom_range(0, 7));
         default: return 32'(sector * SECTOR_BYTES + $urandom_range(0, SECTOR_BYTES - 1));
      endcase
   endfunction

   // erase a sector, program a few words in it, clear more bits, read back, check
   task automatic program_run();
      int          sector;
      int          n;
      logic        allow;
      logic [31:0] base;
      logic [31:0] word_addr;
      logic [31:0] d;
      sector = busy_sector();
      base   = 32'(sector * SECTOR_BYTES);
      allow  = (sector == 0) ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1));
      send_cmd(MODE_ERASE, base + $urandom_range(0, SECTOR_BYTES - 1), $urandom, allow,
               1'($urandom_range(0, 1)));
      n = $urandom_range(1, 4);
      repeat (n) begin
         word_addr = base + 4 * $urandom_range(0, SECTOR_WORDS - 1);
         d         = $urandom & $urandom;
         send_cmd(MODE_PROGRAM, word_addr, d, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
         if ($urandom_range(0, 1)) begin
            d = d & $urandom;
            send_cmd(MODE_PROGRAM, word_addr, d, allow, 1'($urandom_range(0, 1)));
         end
         if ($urandom_range(0, 3) == 0)
            send_cmd(MODE_PROGRAM, word_addr, ERASED_WORD, allow, 1'b1);
         send_cmd(MODE_READ, word_addr + $urandom_range(0, 3), $urandom,
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      send_cmd(MODE_CHECK, base + $urandom_range(0, SECTOR_BYTES - 1), $urandom,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   task automatic noise_cmd();
      logic [2:0] op;
      case ($urandom_range(0, 15))
         0:           op = MODE_FIND;
         1:           op = 3'(MODE_READ) + 3'($urandom_range(1, 3));
         2, 3, 4:     op = MODE_CHECK;
         5, 6, 7:     op = MODE_ERASE;
         8, 9, 10, 11: op = MODE_PROGRAM;
         default:     op = MODE_READ;
      endcase
      send_cmd(op, pick_addr(op != MODE_PROGRAM), $urandom, 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)));
   endtask

   // dirty every sector above zero, search (none left), free the last, search again
   task automatic fill_every_sector();
      int          s;
      logic [31:0] d;
      for (s = 1; s < SECTORS; s++) begin
         d = $urandom & ~(32'd1 << $urandom_range(0, 31));
         send_cmd(MODE_PROGRAM, 32'(s * SECTOR_BYTES + 4 * $urandom_range(0, SECTOR_WORDS - 1)),
                  d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
      send_cmd(MODE_FIND, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_cmd(MODE_ERASE, 32'(LAST_BASE + $urandom_range(0, SECTOR_BYTES - 1)), $urandom,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_cmd(MODE_FIND, $urandom, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      send_cmd(MODE_CHECK, 32'(LAST_BASE), $urandom, 1'b0, 1'b0);
   endtask

   initial begin
      int  directed_count;
      bit  drained;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_cmd(MODE_CHECK, 32'h0, 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_FIND, 32'h0, 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_READ, 32'h0, '1, 1'b1, 1'b1);
      // sector zero is protected without a flag
      send_cmd(MODE_PROGRAM, 32'h0, 32'h1234_5678, 1'b0, 1'b0);
      send_cmd(MODE_PROGRAM, 32'h0, 32'h1234_5678, 1'b0, 1'b1);
      send_cmd(MODE_ERASE, 32'h10, 32'h0, 1'b0, 1'b1);
      send_cmd(MODE_READ, 32'h3, 32'h0, 1'b0, 1'b0);
      // setting bits must fail and leave the word alone
      send_cmd(MODE_PROGRAM, 32'h0, ERASED_WORD, 1'b1, 1'b1);
      send_cmd(MODE_PROGRAM, 32'(SECTOR_BYTES + 2), 32'h0, 1'b1, 1'b1);
      send_cmd(MODE_PROGRAM, 32'(FLASH_BYTES - 4), 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_READ, 32'(FLASH_BYTES - 4), 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_READ, 32'(FLASH_BYTES), 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_PROGRAM, 32'hFFFF_FFFC, 32'h0, 1'b1, 1'b1);
      send_cmd(MODE_ERASE, '1, '1, 1'b1, 1'b1);
      send_cmd(MODE_CHECK, '1, '1, 1'b1, 1'b1);
      send_cmd(MODE_CHECK, 32'(FLASH_BYTES - 1), 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_ERASE, 32'h7FF, 32'h0, 1'b1, 1'b0);
      send_cmd(MODE_CHECK, 32'h0, 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_ERASE, 32'(LAST_BASE + 4), 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_PROGRAM, 32'(SECTOR_BYTES), 32'h0, 1'b0, 1'b0);
      send_cmd(MODE_FIND, '1, '1, 1'b1, 1'b1);
      send_cmd(3'(MODE_READ) + 3'd1, '1, '1, 1'b1, 1'b1);
      send_cmd(3'(MODE_READ) + 3'd2, 32'h0, 32'h0, 1'b0, 1'b0);
      send_cmd(3'(MODE_READ) + 3'd3, '1, '1, 1'b1, 1'b1);
      directed_count = items_sent;

      while (items_sent - directed_count < RANDOM_GOAL) begin
         if (!drained && items_sent - directed_count >= RANDOM_GOAL / 2) begin
            drain_results();
            drained = 1'b1;
         end
         if ($urandom_range(0, 9) < 6) program_run();
         else repeat ($urandom_range(1, 4)) noise_cmd();
      end
      fill_every_sector();

      drain_results();
      repeat (16) @(posedge clock);
      $display("tb_top: %0d requests: %0d check, %0d erase, %0d program, %0d find, %0d read",
               items_sent, mode_sent[MODE_CHECK], mode_sent[MODE_ERASE],
               mode_sent[MODE_PROGRAM], mode_sent[MODE_FIND], mode_sent[MODE_READ]);
      $display("tb_top: %0d bad-mode requests, %0d results compared, %0d mismatches",
               items_sent - mode_sent[MODE_CHECK] - mode_sent[MODE_ERASE]
               - mode_sent[MODE_PROGRAM] - mode_sent[MODE_FIND] - mode_sent[MODE_READ],
               checked_count, mismatch_count);
      if (mismatch_count == 0 && owed_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/nfac_pkg.sv
hw/rtl/nfac_ram.sv
hw/rtl/nfac_sector_div.sv
hw/rtl/nor_flash_array_controller_top.sv
tb/flash_cmd_checker.sv
tb/tb_top.sv
